FILE: rtl/lfs_pkg.sv
// Package for the launcher firing sequencer: state, command and status codes,
// payload and configuration structs, queue sizing. Depends on nothing.
`default_nettype none
package lfs_pkg;

    localparam int TIMER_BITS  = 24;
    localparam int CMP_W       = (TIMER_BITS > 24) ? TIMER_BITS : 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 5;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX      = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] COOLDOWN_TICKS = TIMER_BITS'(100);
    localparam logic [6:0]            POWER_MAX      = 7'd100;
    localparam logic [11:0]           PULSE_MAX      = 12'd4095;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_ARM      = 3'd1;
    localparam logic [2:0] MODE_DISARM   = 3'd2;
    localparam logic [2:0] MODE_FIRE     = 3'd3;
    localparam logic [2:0] MODE_CALIB    = 3'd4;
    localparam logic [2:0] MODE_ESCTEST  = 3'd5;
    localparam logic [2:0] MODE_ACTIVITY = 3'd6;

    localparam logic [2:0] REG_ARM_DELAY    = 3'd0;
    localparam logic [2:0] REG_SPINUP       = 3'd1;
    localparam logic [2:0] REG_BRAKE        = 3'd2;
    localparam logic [2:0] REG_AUTO_DISARM  = 3'd3;
    localparam logic [2:0] REG_SHOT_DUR     = 3'd4;
    localparam logic [2:0] REG_NEUTRAL      = 3'd5;
    localparam logic [2:0] REG_PUSH_OFFSET  = 3'd6;
    localparam logic [2:0] REG_BRAKE_OFFSET = 3'd7;

    localparam logic [3:0] STS_NONE      = 4'd0;
    localparam logic [3:0] STS_ARMING    = 4'd1;
    localparam logic [3:0] STS_ARMED     = 4'd2;
    localparam logic [3:0] STS_DISARMING = 4'd3;
    localparam logic [3:0] STS_DISARMED  = 4'd4;
    localparam logic [3:0] STS_SPINUP    = 4'd5;
    localparam logic [3:0] STS_SHOT_DONE = 4'd6;
    localparam logic [3:0] STS_ESCTEST   = 4'd7;
    localparam logic [3:0] STS_ARM_FIRST = 4'd8;
    localparam logic [3:0] STS_CALIB     = 4'd9;
    localparam logic [3:0] STS_CAL_DONE  = 4'd10;

    localparam logic [1:0] LINK_NONE   = 2'd0;
    localparam logic [1:0] LINK_ATTACH = 2'd1;
    localparam logic [1:0] LINK_DETACH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_ARMING    = 4'd1,
        ST_ARMED     = 4'd2,
        ST_DISARMING = 4'd3,
        ST_DISARMED  = 4'd4,
        ST_SPINUP    = 4'd5,
        ST_PUSH      = 4'd6,
        ST_BRAKE     = 4'd7,
        ST_COOLDOWN  = 4'd8,
        ST_ESCTEST   = 4'd9,
        ST_CALIB     = 4'd10
    } t_state;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_ARM,
        CMD_DISARM,
        CMD_FIRE,
        CMD_CALIB,
        CMD_ESCTEST,
        CMD_ACTIVITY,
        CMD_NONE
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] power;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  fsm_state;
        logic        armed;
        logic        power_valid;
        logic [6:0]  power_value;
        logic        servo_valid;
        logic [11:0] servo_pulse;
        logic [1:0]  esc_link;
        logic [1:0]  shot_link;
        logic [3:0]  status;
    } t_out_word;

    typedef struct packed {
        t_cmd       cmd;
        logic [6:0] power;
    } t_cmd_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [15:0] arm_delay_ticks;
        logic [15:0] spinup_ticks;
        logic [15:0] brake_ticks;
        logic [23:0] disarm_timeout;
        logic [15:0] shot_duration_ms;
        logic [11:0] shot_neutral_us;
        logic [11:0] push_offset_us;
        logic [11:0] brake_offset_us;
    } t_cfg;

endpackage
`default_nettype wire

FILE: rtl/lfs_cfg_regs.sv
// Configuration register bank with an APB-style write and read port.
// Depends on lfs_pkg for the register indexes and the configuration struct.
`default_nettype none
module lfs_cfg_regs
    import lfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_delay_ticks  <= 16'd2000;
            r_cfg.spinup_ticks     <= 16'd300;
            r_cfg.brake_ticks      <= 16'd100;
            r_cfg.disarm_timeout   <= 24'd60000;
            r_cfg.shot_duration_ms <= 16'd150;
            r_cfg.shot_neutral_us  <= 12'd1500;
            r_cfg.push_offset_us   <= 12'd500;
            r_cfg.brake_offset_us  <= 12'd200;
        end else if (wr_en) begin
            unique case (idx)
                REG_ARM_DELAY:    r_cfg.arm_delay_ticks  <= pwdata[15:0];
                REG_SPINUP:       r_cfg.spinup_ticks     <= pwdata[15:0];
                REG_BRAKE:        r_cfg.brake_ticks      <= pwdata[15:0];
                REG_AUTO_DISARM:  r_cfg.disarm_timeout   <= pwdata[23:0];
                REG_SHOT_DUR:     r_cfg.shot_duration_ms <= pwdata[15:0];
                REG_NEUTRAL:      r_cfg.shot_neutral_us  <= pwdata[11:0];
                REG_PUSH_OFFSET:  r_cfg.push_offset_us   <= pwdata[11:0];
                REG_BRAKE_OFFSET: r_cfg.brake_offset_us  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ARM_DELAY:    prdata = 32'(r_cfg.arm_delay_ticks);
            REG_SPINUP:       prdata = 32'(r_cfg.spinup_ticks);
            REG_BRAKE:        prdata = 32'(r_cfg.brake_ticks);
            REG_AUTO_DISARM:  prdata = 32'(r_cfg.disarm_timeout);
            REG_SHOT_DUR:     prdata = 32'(r_cfg.shot_duration_ms);
            REG_NEUTRAL:      prdata = 32'(r_cfg.shot_neutral_us);
            REG_PUSH_OFFSET:  prdata = 32'(r_cfg.push_offset_us);
            REG_BRAKE_OFFSET: prdata = 32'(r_cfg.brake_offset_us);
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/lfs_front.sv
// Front end: accepts input words, decodes the mode and clamps the power.
// Depends on lfs_pkg for the payload and command types.
`default_nettype none
module lfs_front
    import lfs_pkg::*;
(
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    input  t_queue_status      i_queue_status,
    output logic               o_push,
    output t_cmd_word          o_cmd_word
);

    assign o_in_ready = !i_queue_status.full;
    assign o_push     = i_in_valid && !i_queue_status.full;

    always_comb begin
        o_cmd_word.power = (i_in_word.power > POWER_MAX) ? POWER_MAX : i_in_word.power;
        unique case (i_in_word.mode)
            MODE_TICK:     o_cmd_word.cmd = CMD_TICK;
            MODE_ARM:      o_cmd_word.cmd = CMD_ARM;
            MODE_DISARM:   o_cmd_word.cmd = CMD_DISARM;
            MODE_FIRE:     o_cmd_word.cmd = CMD_FIRE;
            MODE_CALIB:    o_cmd_word.cmd = CMD_CALIB;
            MODE_ESCTEST:  o_cmd_word.cmd = CMD_ESCTEST;
            MODE_ACTIVITY: o_cmd_word.cmd = CMD_ACTIVITY;
            default:       o_cmd_word.cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/lfs_queue.sv
// Short register queue of decoded command words between front and back end.
// Depends on lfs_pkg for the word type and the queue depth.
`default_nettype none
module lfs_queue
    import lfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  t_cmd_word     i_word,
    input  wire logic     i_pop,
    output t_cmd_word     o_word,
    output t_queue_status o_status
);

    t_cmd_word         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_word         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lfs_back.sv
// Back end: carries out commands and ticks on the sequencer state and drives
// the registered result word. Depends on lfs_pkg.
`default_nettype none
module lfs_back
    import lfs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  t_cfg           i_cfg,
    input  t_queue_status  i_queue_status,
    input  t_cmd_word      i_word,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    t_state                r_cur, n_cur, r_pend, n_pend;
    logic                  r_armed, n_armed;
    logic [6:0]            r_target, n_target;
    logic [TIMER_BITS-1:0] r_stimer, n_stimer, r_itimer, n_itimer;
    logic [TIMER_BITS-1:0] st_inc, it_inc;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out, res;
    logic [12:0]           push_sum;
    logic                  auto_disarm;

    assign o_pop       = !i_queue_status.empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign st_inc   = (r_stimer == TIMER_MAX) ? TIMER_MAX : r_stimer + 1'b1;
    assign it_inc   = (r_itimer == TIMER_MAX) ? TIMER_MAX : r_itimer + 1'b1;
    assign push_sum = {1'b0, i_cfg.shot_neutral_us} + {1'b0, i_cfg.push_offset_us};
    assign auto_disarm = r_armed && (r_cur == ST_ARMED || r_cur == ST_IDLE)
                         && (CMP_W'(it_inc) > CMP_W'(i_cfg.disarm_timeout));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= ST_IDLE;
            r_pend      <= ST_IDLE;
            r_armed     <= 1'b0;
            r_target    <= '0;
            r_stimer    <= '0;
            r_itimer    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_pend      <= n_pend;
            r_armed     <= n_armed;
            r_target    <= n_target;
            r_stimer    <= n_stimer;
            r_itimer    <= n_itimer;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_cur    = r_cur;
        n_pend   = r_pend;
        n_armed  = r_armed;
        n_target = r_target;
        n_stimer = r_stimer;
        n_itimer = r_itimer;
        res      = '0;

        unique case (i_word.cmd)
            CMD_TICK: begin
                if (r_pend != r_cur) begin
                    n_cur    = r_pend;
                    n_stimer = '0;
                    unique case (r_pend)
                        ST_ARMING: begin
                            res.esc_link = LINK_ATTACH;
                            res.status   = STS_ARMING;
                        end
                        ST_ARMED: begin
                            n_armed    = 1'b1;
                            res.status = STS_ARMED;
                        end
                        ST_DISARMING: begin
                            n_armed    = 1'b0;
                            res.status = STS_DISARMING;
                        end
                        ST_DISARMED: begin
                            res.esc_link  = LINK_DETACH;
                            res.shot_link = LINK_DETACH;
                            res.status    = STS_DISARMED;
                        end
                        ST_SPINUP: begin
                            res.power_valid = 1'b1;
                            res.power_value = r_target;
                            res.status      = STS_SPINUP;
                        end
                        ST_PUSH: begin
                            res.shot_link   = LINK_ATTACH;
                            res.servo_valid = 1'b1;
                            res.servo_pulse = push_sum[12] ? PULSE_MAX : push_sum[11:0];
                        end
                        ST_BRAKE: begin
                            res.servo_valid = 1'b1;
                            res.servo_pulse =
                                (i_cfg.brake_offset_us > i_cfg.shot_neutral_us) ? 12'd0
                                : i_cfg.shot_neutral_us - i_cfg.brake_offset_us;
                        end
                        ST_COOLDOWN: begin
                            res.servo_valid = 1'b1;
                            res.servo_pulse = i_cfg.shot_neutral_us;
                            res.power_valid = 1'b1;
                        end
                        ST_IDLE: begin
                            if (r_cur == ST_COOLDOWN) begin
                                res.shot_link = LINK_DETACH;
                                res.status    = STS_SHOT_DONE;
                            end
                        end
                        ST_ESCTEST: begin
                            res.power_valid = 1'b1;
                            res.power_value = r_target;
                            res.status      = STS_ESCTEST;
                        end
                        default: ;
                    endcase
                end else begin
                    n_stimer = st_inc;
                    n_itimer = it_inc;
                    if (auto_disarm) begin
                        n_pend = ST_DISARMING;
                    end else begin
                        unique case (r_cur)
                            ST_ARMING: begin
                                if (st_inc >= TIMER_BITS'(i_cfg.arm_delay_ticks)) begin
                                    n_pend = ST_ARMED;
                                end
                            end
                            ST_DISARMING: n_pend = ST_DISARMED;
                            ST_SPINUP: begin
                                if (st_inc >= TIMER_BITS'(i_cfg.spinup_ticks)) n_pend = ST_PUSH;
                            end
                            ST_PUSH: begin
                                if (st_inc >= TIMER_BITS'(i_cfg.shot_duration_ms)) begin
                                    n_pend = ST_BRAKE;
                                end
                            end
                            ST_BRAKE: begin
                                if (st_inc >= TIMER_BITS'(i_cfg.brake_ticks)) begin
                                    n_pend = ST_COOLDOWN;
                                end
                            end
                            ST_COOLDOWN: begin
                                if (st_inc >= COOLDOWN_TICKS) n_pend = ST_ARMED;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_ARM: begin
                n_itimer = '0;
                if (!r_armed && r_cur != ST_ARMING) begin
                    n_pend   = ST_ARMING;
                    n_stimer = '0;
                end
            end
            CMD_DISARM: begin
                if (r_cur == ST_CALIB) begin
                    n_cur      = ST_IDLE;
                    n_pend     = ST_IDLE;
                    res.status = STS_CAL_DONE;
                end else begin
                    n_pend   = ST_DISARMING;
                    n_stimer = '0;
                end
            end
            CMD_FIRE: begin
                if (!r_armed) begin
                    res.status = STS_ARM_FIRST;
                end else if (r_cur == ST_ARMED || r_cur == ST_IDLE) begin
                    n_target = i_word.power;
                    n_pend   = ST_SPINUP;
                    n_stimer = '0;
                    n_itimer = '0;
                end
            end
            CMD_CALIB: begin
                if (!r_armed) begin
                    res.status = STS_ARM_FIRST;
                end else begin
                    res.esc_link = LINK_ATTACH;
                    n_cur        = ST_CALIB;
                    n_pend       = ST_CALIB;
                    res.status   = STS_CALIB;
                end
            end
            CMD_ESCTEST: begin
                if (!r_armed) begin
                    res.status = STS_ARM_FIRST;
                end else begin
                    n_target = i_word.power;
                    n_pend   = ST_ESCTEST;
                    n_stimer = '0;
                    n_itimer = '0;
                end
            end
            CMD_ACTIVITY: n_itimer = '0;
            default: ;
        endcase

        res.fsm_state = n_cur;
        res.armed     = n_armed;

        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (!o_pop) begin
            n_cur    = r_cur;
            n_pend   = r_pend;
            n_armed  = r_armed;
            n_target = r_target;
            n_stimer = r_stimer;
            n_itimer = r_itimer;
        end
    end

`ifndef SYNTH
    a_arm_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_word.cmd == CMD_TICK && r_pend == ST_ARMED && r_cur != ST_ARMED)
        |=> (r_armed && r_cur == ST_ARMED))
        else $error("armed state entered without setting the armed flag");
    a_cal_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STS_CAL_DONE) |-> (r_out.fsm_state == ST_IDLE))
        else $error("calibration finished reported outside idle");
    a_power_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.power_valid) |-> (r_out.power_value == 7'd0))
        else $error("power value without a power command");
    a_servo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.servo_valid) |-> (r_out.servo_pulse == 12'd0))
        else $error("servo pulse without a servo command");
`endif

endmodule
`default_nettype wire

FILE: rtl/launcher_firing_sequencer.sv
// Throughput: one word per cycle while words wait and the output is not held by i_out_ready.
// A two-entry queue parts front and back; the output register holds a result
// while the next word is taken. Reset (synchronous, active low) makes the
// state idle, disarms, clears the timers and loads the default configuration.
`default_nettype none
module launcher_firing_sequencer
    import lfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  t_in_word                i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_word               o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    t_cfg          cfg;
    t_queue_status q_status;
    t_cmd_word     push_word, head_word;
    logic          push, pop;

    lfs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfs_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_word      (i_in_word),
        .i_queue_status (q_status),
        .o_push         (push),
        .o_cmd_word     (push_word)
    );

    lfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (push_word),
        .i_pop    (pop),
        .o_word   (head_word),
        .o_status (q_status)
    );

    lfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_queue_status (q_status),
        .i_word         (head_word),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_word)
    );

endmodule
`default_nettype wire

FILE: dv/lfs_checker.sv
`timescale 1ns / 1ps
// Watches both word channels and the register port of the firing sequencer,
// predicts each result word from its own copy of state and configuration, and
// compares in order. Depends on lfs_pkg.
module lfs_checker
    import lfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  t_in_word                i_in_word,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  t_out_word               i_out_word,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    t_cfg                  cfg;
    t_state                fsm_now;
    t_state                fsm_queued;
    logic                  is_armed;
    logic [6:0]            target_pct;
    logic [TIMER_BITS-1:0] dwell_ticks;
    logic [TIMER_BITS-1:0] quiet_ticks;
    t_out_word             expected_words[$];
    t_out_word             want;
    int                    result_idx;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (t == TIMER_MAX) ? t : t + 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 100) begin
            $display("%0t: result word %0d: %s", $time, result_idx, msg);
        end
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int exp_val);
        if (got != exp_val) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
        end
    endtask

    task automatic step_sequencer(input t_in_word w, output t_out_word r);
        t_state      prev;
        t_state      nxt;
        logic [6:0]  pct;
        logic [12:0] push_sum;
        r        = '0;
        pct      = (w.power > POWER_MAX) ? POWER_MAX : w.power;
        push_sum = {1'b0, cfg.shot_neutral_us} + {1'b0, cfg.push_offset_us};
        case (w.mode)
            MODE_TICK: begin
                if (fsm_queued != fsm_now) begin
                    prev        = fsm_now;
                    fsm_now     = fsm_queued;
                    dwell_ticks = '0;
                    case (fsm_now)
                        ST_ARMING: begin
                            r.esc_link = LINK_ATTACH;
                            r.status   = STS_ARMING;
                        end
                        ST_ARMED: begin
                            is_armed = 1'b1;
                            r.status = STS_ARMED;
                        end
                        ST_DISARMING: begin
                            is_armed = 1'b0;
                            r.status = STS_DISARMING;
                        end
                        ST_DISARMED: begin
                            r.esc_link  = LINK_DETACH;
                            r.shot_link = LINK_DETACH;
                            r.status    = STS_DISARMED;
                        end
                        ST_SPINUP: begin
                            r.power_valid = 1'b1;
                            r.power_value = target_pct;
                            r.status      = STS_SPINUP;
                        end
                        ST_PUSH: begin
                            r.shot_link   = LINK_ATTACH;
                            r.servo_valid = 1'b1;
                            r.servo_pulse = (push_sum > PULSE_MAX) ? PULSE_MAX : push_sum[11:0];
                        end
                        ST_BRAKE: begin
                            r.servo_valid = 1'b1;
                            r.servo_pulse = (cfg.brake_offset_us > cfg.shot_neutral_us) ? '0 :
                                            cfg.shot_neutral_us - cfg.brake_offset_us;
                        end
                        ST_COOLDOWN: begin
                            r.servo_valid = 1'b1;
                            r.servo_pulse = cfg.shot_neutral_us;
                            r.power_valid = 1'b1;
                            r.power_value = '0;
                        end
                        ST_IDLE: begin
                            if (prev == ST_COOLDOWN) begin
                                r.shot_link = LINK_DETACH;
                                r.status    = STS_SHOT_DONE;
                            end
                        end
                        ST_ESCTEST: begin
                            r.power_valid = 1'b1;
                            r.power_value = target_pct;
                            r.status      = STS_ESCTEST;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    nxt         = fsm_now;
                    dwell_ticks = sat_inc(dwell_ticks);
                    quiet_ticks = sat_inc(quiet_ticks);
                    if (is_armed && (fsm_now == ST_ARMED || fsm_now == ST_IDLE)
                            && quiet_ticks > cfg.disarm_timeout) begin
                        nxt = ST_DISARMING;
                    end else begin
                        case (fsm_now)
                            ST_ARMING:    if (dwell_ticks >= cfg.arm_delay_ticks) nxt = ST_ARMED;
                            ST_DISARMING: nxt = ST_DISARMED;
                            ST_SPINUP:    if (dwell_ticks >= cfg.spinup_ticks) nxt = ST_PUSH;
                            ST_PUSH:      if (dwell_ticks >= cfg.shot_duration_ms) nxt = ST_BRAKE;
                            ST_BRAKE:     if (dwell_ticks >= cfg.brake_ticks) nxt = ST_COOLDOWN;
                            ST_COOLDOWN:  if (dwell_ticks >= COOLDOWN_TICKS) nxt = ST_ARMED;
                            default: begin
                            end
                        endcase
                    end
                    fsm_queued = nxt;
                end
            end
            MODE_ARM: begin
                quiet_ticks = '0;
                if (!is_armed && fsm_now != ST_ARMING) begin
                    fsm_queued  = ST_ARMING;
                    dwell_ticks = '0;
                end
            end
            MODE_DISARM: begin
                if (fsm_now == ST_CALIB) begin
                    fsm_now    = ST_IDLE;
                    fsm_queued = ST_IDLE;
                    r.status   = STS_CAL_DONE;
                end else begin
                    fsm_queued  = ST_DISARMING;
                    dwell_ticks = '0;
                end
            end
            MODE_FIRE: begin
                if (!is_armed) begin
                    r.status = STS_ARM_FIRST;
                end else if (fsm_now == ST_ARMED || fsm_now == ST_IDLE) begin
                    target_pct  = pct;
                    fsm_queued  = ST_SPINUP;
                    dwell_ticks = '0;
                    quiet_ticks = '0;
                end
            end
            MODE_CALIB: begin
                if (!is_armed) begin
                    r.status = STS_ARM_FIRST;
                end else begin
                    r.esc_link = LINK_ATTACH;
                    fsm_now    = ST_CALIB;
                    fsm_queued = ST_CALIB;
                    r.status   = STS_CALIB;
                end
            end
            MODE_ESCTEST: begin
                if (!is_armed) begin
                    r.status = STS_ARM_FIRST;
                end else begin
                    target_pct  = pct;
                    fsm_queued  = ST_ESCTEST;
                    dwell_ticks = '0;
                    quiet_ticks = '0;
                end
            end
            MODE_ACTIVITY: begin
                quiet_ticks = '0;
            end
            default: begin
            end
        endcase
        r.fsm_state = fsm_now;
        r.armed     = is_armed;
    endtask

    // Everything is sampled at the falling edge; the transfer it describes
    // happens at the rising edge that follows.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            fsm_now              = ST_IDLE;
            fsm_queued           = ST_IDLE;
            is_armed             = 1'b0;
            target_pct           = '0;
            dwell_ticks          = '0;
            quiet_ticks          = '0;
            cfg.arm_delay_ticks  = 16'd2000;
            cfg.spinup_ticks     = 16'd300;
            cfg.brake_ticks      = 16'd100;
            cfg.disarm_timeout   = 24'd60000;
            cfg.shot_duration_ms = 16'd150;
            cfg.shot_neutral_us  = 12'd1500;
            cfg.push_offset_us   = 12'd500;
            cfg.brake_offset_us  = 12'd200;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word arrived with no expectation waiting");
                end else begin
                    want = expected_words.pop_front();
                    compare_field("fsm_state", i_out_word.fsm_state, want.fsm_state);
                    compare_field("armed", i_out_word.armed, want.armed);
                    compare_field("power_valid", i_out_word.power_valid, want.power_valid);
                    compare_field("power_value", i_out_word.power_value, want.power_value);
                    compare_field("servo_valid", i_out_word.servo_valid, want.servo_valid);
                    compare_field("servo_pulse", i_out_word.servo_pulse, want.servo_pulse);
                    compare_field("esc_link", i_out_word.esc_link, want.esc_link);
                    compare_field("shot_link", i_out_word.shot_link, want.shot_link);
                    compare_field("status", i_out_word.status, want.status);
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                step_sequencer(i_in_word, want);
                expected_words.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_ARM_DELAY:    cfg.arm_delay_ticks  = i_pwdata[15:0];
                    REG_SPINUP:       cfg.spinup_ticks     = i_pwdata[15:0];
                    REG_BRAKE:        cfg.brake_ticks      = i_pwdata[15:0];
                    REG_AUTO_DISARM:  cfg.disarm_timeout   = i_pwdata[23:0];
                    REG_SHOT_DUR:     cfg.shot_duration_ms = i_pwdata[15:0];
                    REG_NEUTRAL:      cfg.shot_neutral_us  = i_pwdata[11:0];
                    REG_PUSH_OFFSET:  cfg.push_offset_us   = i_pwdata[11:0];
                    REG_BRAKE_OFFSET: cfg.brake_offset_us  = i_pwdata[11:0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_words.size();
    end

endmodule

FILE: dv/launcher_firing_sequencer_tb.sv
`timescale 1ns / 1ps
// Top of the firing sequencer testbench: clock, reset, register writes and
// command and tick words, with the verdict. Depends on lfs_pkg and lfs_checker.
module launcher_firing_sequencer_tb;
    import lfs_pkg::*;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_word           i_in_word   = '0;
    logic               i_out_ready = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_word          o_out_word;
    logic [31:0]        prdata;
    logic               pready;
    int                 send_idle   = 26;
    int                 recv_idle   = 78;
    int                 fail_count;
    int                 pending;

    launcher_firing_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lfs_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input logic [2:0] mode, input logic [6:0] pct);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= {mode, pct};
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(REG_ARM_DELAY, 32'(c.arm_delay_ticks));
        write_reg(REG_SPINUP, 32'(c.spinup_ticks));
        write_reg(REG_BRAKE, 32'(c.brake_ticks));
        write_reg(REG_AUTO_DISARM, 32'(c.disarm_timeout));
        write_reg(REG_SHOT_DUR, 32'(c.shot_duration_ms));
        write_reg(REG_NEUTRAL, 32'(c.shot_neutral_us));
        write_reg(REG_PUSH_OFFSET, 32'(c.push_offset_us));
        write_reg(REG_BRAKE_OFFSET, 32'(c.brake_offset_us));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_cfg random_timing_cfg(input int span);
        t_cfg c;
        c.arm_delay_ticks  = 16'($urandom_range(span));
        c.spinup_ticks     = 16'($urandom_range(span));
        c.brake_ticks      = 16'($urandom_range(span));
        c.disarm_timeout   = 24'($urandom_range(8 * span + 10));
        c.shot_duration_ms = 16'($urandom_range(span));
        c.shot_neutral_us  = 12'($urandom_range(4095));
        c.push_offset_us   = 12'($urandom_range(4095));
        c.brake_offset_us  = 12'($urandom_range(4095));
        return c;
    endfunction

    // Mostly a command followed by a run of ticks; after a fire the run is
    // more often long enough to see the cooldown through to armed again.
    task automatic random_bursts(input int n);
        int         sent;
        int         pick;
        int         run;
        int         sel;
        logic [6:0] pct;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            sel  = $urandom_range(9);
            pct  = (sel == 0) ? POWER_MAX : (sel == 1) ? 7'h7F : (sel == 2) ? 7'd0 :
                   7'($urandom_range(127));
            if (pick < 24) begin
                send_word(MODE_FIRE, pct);
            end else if (pick < 38) begin
                send_word(MODE_ARM, pct);
            end else if (pick < 47) begin
                send_word(MODE_ESCTEST, pct);
            end else if (pick < 55) begin
                send_word(MODE_ACTIVITY, pct);
            end else if (pick < 62) begin
                send_word(MODE_DISARM, pct);
            end else if (pick < 67) begin
                send_word(MODE_CALIB, pct);
            end else if (pick < 70) begin
                send_word(CMD_NONE, pct);
            end
            if (pick < 67) sent++;
            if ($urandom_range(9) < ((pick < 24) ? 3 : 1)) begin
                run = $urandom_range(90, 130);
            end else begin
                run = $urandom_range(6);
            end
            repeat (run) begin
                send_word(MODE_TICK, 7'($urandom_range(127)));
                sent++;
            end
        end
    endtask

    initial begin
        t_cfg c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default configuration: commands refused while unarmed, an unknown
        // mode, a full disarm sequence and the start of arming.
        send_word(CMD_NONE, 7'h7F);
        send_word(MODE_FIRE, 7'h7F);
        send_word(MODE_CALIB, 7'd0);
        send_word(MODE_ESCTEST, 7'd0);
        send_word(MODE_DISARM, 7'd0);
        repeat (3) send_word(MODE_TICK, 7'd0);
        send_word(MODE_ACTIVITY, 7'h7F);
        send_word(MODE_ARM, 7'd0);
        send_word(MODE_TICK, 7'h7F);
        wait_drained();

        // Short timings and a neutral pulse high enough that pushing saturates.
        c.arm_delay_ticks  = 16'd2;
        c.spinup_ticks     = 16'd1;
        c.brake_ticks      = 16'd1;
        c.disarm_timeout   = 24'd30;
        c.shot_duration_ms = 16'd1;
        c.shot_neutral_us  = 12'd4000;
        c.push_offset_us   = 12'd500;
        c.brake_offset_us  = 12'd200;
        load_config(c);
        repeat (3) send_word(MODE_TICK, 7'd0);
        send_word(MODE_FIRE, 7'h7F);
        repeat (7) send_word(MODE_TICK, 7'd0);
        send_word(MODE_CALIB, 7'd0);
        send_word(MODE_DISARM, 7'd0);
        send_word(MODE_ESCTEST, 7'd64);
        send_word(MODE_TICK, 7'd0);
        random_bursts(90);

        for (int ph = 1; ph < 6; ph++) begin
            wait_drained();
            send_idle = (ph < 2) ? 26 : (ph < 4) ? 78 : 0;
            recv_idle = (ph < 2) ? 78 : (ph < 4) ? 26 : 0;
            case (ph)
                1: begin
                    c = '0;
                    c.brake_offset_us = 12'hFFF;
                end
                2: c = random_timing_cfg(8);
                3: begin
                    c = '1;
                    c.disarm_timeout = 24'd16777214;
                end
                4: c = random_timing_cfg(20);
                default: c = random_timing_cfg(4);
            endcase
            load_config(c);
            random_bursts(90);
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(400000 * 12);
        $display("status: fail");
        $finish;
    end

endmodule
